/* rtl/core/msdrs_pkg.sv */
`default_nettype none
package msdrs_pkg;

   localparam int Capacity   = 1024;
   localparam int KeyBits    = 32;
   localparam int MaxRadix   = 8;
   localparam int IdxW       = $clog2(Capacity);
   localparam int CntW       = IdxW + 1;
   localparam int MaxBuckets = 1 << MaxRadix;
   localparam int BktW       = $clog2(MaxBuckets);
   localparam int DigW       = $clog2(KeyBits);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                op;
      logic [KeyBits-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [KeyBits-1:0]  sorted_key;
      logic                last;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic [CntW-1:0] lo;
      logic [CntW-1:0] hi;
      logic [DigW-1:0] dig;
   } span_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP,
      S_POPW,
      S_CLR,
      S_CNT_RD,
      S_CNT_K,
      S_CNT_W,
      S_PFX_RD,
      S_PFX_W,
      S_SC_RD,
      S_SC_K,
      S_SC_W,
      S_PU_RD,
      S_PU_W,
      S_DRAIN
   } state_type;

   // clamp the radix register to 1..MaxRadix
   function automatic logic [3:0] eff_bits(input logic [3:0] r);
      logic [3:0] b;
      b = r;
      if (r == 4'd0) begin
         b = 4'd1;
      end else if (r > 4'(MaxRadix)) begin
         b = 4'(MaxRadix);
      end
      return b;
   endfunction

   // index of the top digit: ceil(32 / bits) - 1
   function automatic logic [DigW-1:0] top_digit(input logic [3:0] b);
      logic [DigW-1:0] t;
      case (b)
         4'd1:    t = 5'd31;
         4'd2:    t = 5'd15;
         4'd3:    t = 5'd10;
         4'd4:    t = 5'd7;
         4'd5:    t = 5'd6;
         4'd6:    t = 5'd5;
         4'd7:    t = 5'd4;
         default: t = 5'd3;
      endcase
      return t;
   endfunction

   function automatic logic [BktW-1:0] digit_of(input logic [KeyBits-1:0] k,
                                               input logic [DigW-1:0] sh,
                                               input logic [3:0] b);
      logic [KeyBits-1:0] s;
      logic [BktW:0]      m;
      s = k >> sh;
      m = (9'd1 << b) - 9'd1;
      return s[BktW-1:0] & m[BktW-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/msdrs_ram.sv */
`default_nettype none
module msdrs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* rtl/core/msd_radix_sorter_core.sv */
`default_nettype none
// msd radix sorter: collects up to 1024 unsigned 32-bit keys and hands them
// back in ascending order. a load's word appears on rsp the cycle after
// start; a drain of an already sorted batch takes one key store read. the
// first drain after any load sorts the whole store first, most significant
// digit first, keeping busy high meanwhile. each range has its buckets
// cleared, its keys counted (key read, count read, count write through the
// single count memory port) and its counts turned into bucket offsets, then
// its keys scattered and its child ranges pushed.
// rsp_valid is a one-cycle strobe and the receiver cannot stall it.
// csr writes are taken only while idle.
module msd_radix_sorter_core
   import msdrs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req,
   output logic            rsp_valid,
   output rsp_type         rsp,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_data
);

   state_type state_ff, state_in;

   // control registers
   logic [CntW-1:0] lc_ff, lc_in;       // keys held
   logic [CntW-1:0] dp_ff, dp_in;       // drain pointer
   logic            sorted_ff, sorted_in;
   logic [3:0]      radix_ff;
   logic [3:0]      bits_ff, bits_in;
   logic [BktW:0]   nbk_ff, nbk_in;     // bucket count this sort
   logic [CntW-1:0] sp_ff, sp_in;       // range stack depth
   logic            rsp_valid_ff, rsp_valid_in;

   // working registers of the current range
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [DigW-1:0] dig_ff, dig_in, shift_ff, shift_in;
   logic [CntW-1:0] idx_ff, idx_in, acc_ff, acc_in;
   logic [BktW-1:0] d_ff, d_in;
   logic [KeyBits-1:0] k_ff, k_in;
   rsp_type         rsp_ff, rsp_in;

   // memory ports
   logic                key_we, scr_we, cnt_we, stk_we;
   logic [IdxW-1:0]     key_wa, key_ra, scr_wa, scr_ra, stk_wa, stk_ra;
   logic [BktW-1:0]     cnt_wa, cnt_ra;
   logic [KeyBits-1:0]  key_wd, key_rd, scr_wd, scr_rd;
   logic [CntW-1:0]     cnt_wd, cnt_rd;
   span_type            stk_wd, stk_rd;

   logic            accept;
   logic [BktW:0]   last_bkt;
   logic [8:0]      shift_prod;
   logic [CntW-1:0] len, span_n;
   logic [BktW-1:0] dig_k;

   msdrs_ram #(.DEPTH(Capacity), .WIDTH(KeyBits)) u_key (
      .clock(clock), .we(key_we), .waddr(key_wa), .wdata(key_wd),
      .raddr(key_ra), .rdata(key_rd));
   msdrs_ram #(.DEPTH(Capacity), .WIDTH(KeyBits)) u_scr (
      .clock(clock), .we(scr_we), .waddr(scr_wa), .wdata(scr_wd),
      .raddr(scr_ra), .rdata(scr_rd));
   msdrs_ram #(.DEPTH(MaxBuckets), .WIDTH(CntW)) u_cnt (
      .clock(clock), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
      .raddr(cnt_ra), .rdata(cnt_rd));
   msdrs_ram #(.DEPTH(Capacity), .WIDTH($bits(span_type))) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_rd));

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign last_bkt  = nbk_ff - 1'b1;
   assign shift_prod = {5'd0, bits_ff} * {4'd0, dig_ff};
   assign len       = hi_ff - lo_ff;
   assign span_n    = cnt_rd - acc_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req.op == OP_DRAIN && dp_ff < lc_ff) begin
               state_in = sorted_ff ? S_DRAIN : S_POP;
            end
         end
         S_POP:    state_in = (sp_ff == '0) ? S_DRAIN : S_POPW;
         S_POPW:   state_in = S_CLR;
         S_CLR:    state_in = (idx_ff == CntW'(last_bkt)) ? S_CNT_RD : S_CLR;
         S_CNT_RD: state_in = (idx_ff == hi_ff) ? S_PFX_RD : S_CNT_K;
         S_CNT_K:  state_in = S_CNT_W;
         S_CNT_W:  state_in = S_CNT_RD;
         S_PFX_RD: state_in = S_PFX_W;
         S_PFX_W:  state_in = (idx_ff == CntW'(last_bkt)) ? S_SC_RD : S_PFX_RD;
         S_SC_RD: begin
            if (idx_ff == len) begin
               state_in = (dig_ff == '0) ? S_POP : S_PU_RD;
            end else begin
               state_in = S_SC_K;
            end
         end
         S_SC_K:   state_in = S_SC_W;
         S_SC_W:   state_in = S_SC_RD;
         S_PU_RD:  state_in = S_PU_W;
         S_PU_W:   state_in = (idx_ff == CntW'(last_bkt)) ? S_POP : S_PU_RD;
         S_DRAIN:  state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      lc_in = lc_ff;  dp_in = dp_ff;  sorted_in = sorted_ff;
      bits_in = bits_ff;  nbk_in = nbk_ff;  sp_in = sp_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  dig_in = dig_ff;  shift_in = shift_ff;
      idx_in = idx_ff;  acc_in = acc_ff;  d_in = d_ff;  k_in = k_ff;
      rsp_in = rsp_ff;  rsp_valid_in = 1'b0;
      key_we = 1'b0; key_wa = '0; key_wd = '0; key_ra = dp_ff[IdxW-1:0];
      scr_we = 1'b0; scr_wa = '0; scr_wd = '0; scr_ra = '0;
      cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
      dig_k = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               if (req.op == OP_LOAD) begin
                  rsp_valid_in = 1'b1;
                  if (lc_ff == CntW'(Capacity)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     key_we    = 1'b1;
                     key_wa    = lc_ff[IdxW-1:0];
                     key_wd    = req.key;
                     lc_in     = lc_ff + 1'b1;
                     sorted_in = 1'b0;
                  end
               end else if (dp_ff >= lc_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_EMPTY;
               end else if (!sorted_ff) begin
                  // seed the stack with the whole store
                  bits_in = eff_bits(radix_ff);
                  nbk_in  = (BktW+1)'(1) << eff_bits(radix_ff);
                  if (lc_ff > CntW'(1)) begin
                     stk_we = 1'b1;
                     stk_wa = '0;
                     stk_wd = '{lo: '0, hi: lc_ff, dig: top_digit(eff_bits(radix_ff))};
                     sp_in  = CntW'(1);
                  end else begin
                     sp_in = '0;
                  end
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               sorted_in = 1'b1;
            end else begin
               stk_ra = sp_ff[IdxW-1:0] - 1'b1;
               sp_in  = sp_ff - 1'b1;
            end
         end
         S_POPW: begin
            lo_in  = stk_rd.lo;
            hi_in  = stk_rd.hi;
            dig_in = stk_rd.dig;
            idx_in = '0;
         end
         S_CLR: begin
            shift_in = shift_prod[DigW-1:0];
            cnt_we = 1'b1;
            cnt_wa = idx_ff[BktW-1:0];
            cnt_wd = '0;
            idx_in = (idx_ff == CntW'(last_bkt)) ? lo_ff : idx_ff + 1'b1;
         end
         S_CNT_RD: begin
            key_ra = idx_ff[IdxW-1:0];
            if (idx_ff == hi_ff) begin
               idx_in = '0;
               acc_in = '0;
            end
         end
         S_CNT_K: begin
            scr_we = 1'b1;
            scr_wa = IdxW'(idx_ff - lo_ff);
            scr_wd = key_rd;
            dig_k  = digit_of(key_rd, shift_ff, bits_ff);
            cnt_ra = dig_k;
            d_in   = dig_k;
         end
         S_CNT_W: begin
            cnt_we = 1'b1;
            cnt_wa = d_ff;
            cnt_wd = cnt_rd + 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         S_PFX_RD: begin
            cnt_ra = idx_ff[BktW-1:0];
         end
         S_PFX_W: begin
            // counts become bucket start offsets
            cnt_we = 1'b1;
            cnt_wa = idx_ff[BktW-1:0];
            cnt_wd = acc_ff;
            acc_in = acc_ff + cnt_rd;
            idx_in = (idx_ff == CntW'(last_bkt)) ? '0 : idx_ff + 1'b1;
         end
         S_SC_RD: begin
            scr_ra = idx_ff[IdxW-1:0];
            if (idx_ff == len) begin
               idx_in = '0;
               acc_in = '0;
            end
         end
         S_SC_K: begin
            k_in   = scr_rd;
            dig_k  = digit_of(scr_rd, shift_ff, bits_ff);
            cnt_ra = dig_k;
            d_in   = dig_k;
         end
         S_SC_W: begin
            key_we = 1'b1;
            key_wa = IdxW'(lo_ff + cnt_rd);
            key_wd = k_ff;
            cnt_we = 1'b1;
            cnt_wa = d_ff;
            cnt_wd = cnt_rd + 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         S_PU_RD: begin
            cnt_ra = idx_ff[BktW-1:0];
         end
         S_PU_W: begin
            // after scatter each count holds its bucket end
            if (span_n > CntW'(1)) begin
               stk_we = 1'b1;
               stk_wa = sp_ff[IdxW-1:0];
               stk_wd = '{lo: lo_ff + acc_ff, hi: lo_ff + cnt_rd, dig: dig_ff - 1'b1};
               sp_in  = sp_ff + 1'b1;
            end
            acc_in = cnt_rd;
            idx_in = idx_ff + 1'b1;
         end
         S_DRAIN: begin
            rsp_valid_in      = 1'b1;
            rsp_in.sorted_key = key_rd;
            rsp_in.status     = ST_OK;
            if (dp_ff + 1'b1 == lc_ff) begin
               rsp_in.last = 1'b1;
               lc_in       = '0;
               dp_in       = '0;
               sorted_in   = 1'b0;
            end else begin
               rsp_in.last = 1'b0;
               dp_in       = dp_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lc_ff        <= '0;
         dp_ff        <= '0;
         sorted_ff    <= 1'b0;
         radix_ff     <= 4'd8;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         dp_ff        <= dp_in;
         sorted_ff    <= sorted_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            radix_ff <= csr_data;
         end
      end
   end

   // payload and loop registers
   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      nbk_ff   <= nbk_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      dig_ff   <= dig_in;
      shift_ff <= shift_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      k_ff     <= k_in;
      rsp_ff   <= rsp_in;
   end

   // a load always answers on the next cycle
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req.op == OP_LOAD |=> rsp_valid)
      else $error("load without response");

   // a final word always carries ok status
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |-> rsp.status == ST_OK)
      else $error("last with error status");

   // no response strobe while sorting
   a_quiet_sort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_IDLE || $past(state_ff) == S_DRAIN)
      else $error("response during sort");

   // the store never holds more than capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      lc_ff <= CntW'(Capacity) && dp_ff <= lc_ff)
      else $error("count out of range");

endmodule
`default_nettype wire
